/* sv/hcpf_pkg.sv */
// Shared widths, latencies, register indexes and sideband types of the contact force core.
package hcpf_pkg;
  localparam int IDX_W   = 8;
  localparam int POS_W   = 32;
  localparam int LEN_W   = 31;
  localparam int DELTA_W = 33;
  localparam int MAG_W   = 32;
  localparam int S_W     = 64;
  localparam int DIST_W  = 33;
  localparam int FORCE_W = 40;
  localparam int VIR_W   = 64;
  localparam int NUM_W   = 42;
  localparam int FRAC_STEPS = 7;

  localparam int STIFF_SOFT = 1;
  localparam int STIFF_HARD = 100;

  localparam int MI_LAT  = MAG_W + 2;
  localparam int ISQ_LAT = S_W / 2 + 2;
  localparam int FD_LAT  = S_W + FRAC_STEPS + 3;

  localparam logic [FORCE_W-1:0] F_MAX = {1'b0, {(FORCE_W-1){1'b1}}};

  typedef enum logic {
    REG_BOX_WIDTH  = 1'b0,
    REG_BOX_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [LEN_W-1:0] sigma;
    logic             bonded;
  } pair_sb_t;

  typedef struct packed {
    pair_sb_t                   sb;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
    logic                       after;
    logic                       k_hard;
    logic                       fz;
  } geo_sb_t;

  typedef struct packed {
    logic [IDX_W-1:0]           idx_a;
    logic [IDX_W-1:0]           idx_b;
    logic                       bonded;
    logic                       after;
    logic                       fz;
    logic                       neg_x;
    logic                       neg_y;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
  } frc_sb_t;
endpackage

/* sv/hcpf_delay.sv */
// Delay line with a reset valid bit beside each payload stage.
module hcpf_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);
  logic [N-1:0] vl;
  logic [W-1:0] dl [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (en) begin
      vl[0] <= vin;
      for (int i = 1; i < N; i++) vl[i] <= vl[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= din;
      for (int i = 1; i < N; i++) dl[i] <= dl[i-1];
    end
  end

  assign vout = vl[N-1];
  assign dout = dl[N-1];
endmodule

/* sv/hcpf_minimg.sv */
// Pipelined minimum-image reduction of one axis, one remainder bit per stage.
module hcpf_minimg import hcpf_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [DELTA_W-1:0] delta,
  input  logic [LEN_W-1:0]          len,
  output logic signed [DELTA_W-1:0] dx
);
  logic [MAG_W-1:0]          num [MAG_W+1];
  logic [MAG_W-1:0]          rem [MAG_W+1];
  logic                      qb  [MAG_W+1];
  logic                      neg [MAG_W+1];
  logic signed [DELTA_W-1:0] dl  [MAG_W+1];
  logic signed [DELTA_W-1:0] dabs;
  logic [MAG_W-1:0]          r;
  logic [MAG_W-1:0]          twor;
  logic                      up;
  logic signed [DELTA_W-1:0] res;
  logic signed [DELTA_W-1:0] dx_next;

  assign dabs = delta[DELTA_W-1] ? -delta : delta;

  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= dabs[MAG_W-1:0];
      rem[0] <= '0;
      qb[0]  <= 1'b0;
      neg[0] <= delta[DELTA_W-1];
      dl[0]  <= delta;
    end
  end

  for (genvar i = 0; i < MAG_W; i++) begin : g_step
    logic [MAG_W-1:0] t;
    logic             ge;
    assign t  = {rem[i][MAG_W-2:0], num[i][MAG_W-1]};
    assign ge = t >= {1'b0, len};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? t - {1'b0, len} : t;
        num[i+1] <= {num[i][MAG_W-2:0], 1'b0};
        qb[i+1]  <= ge;
        neg[i+1] <= neg[i];
        dl[i+1]  <= dl[i];
      end
    end
  end

  assign r    = rem[MAG_W];
  assign twor = {r[MAG_W-2:0], 1'b0};
  assign up   = (twor > {1'b0, len}) || ((twor == {1'b0, len}) && qb[MAG_W]);
  assign res  = up ? $signed({1'b0, r}) - $signed({2'b0, len}) : $signed({1'b0, r});

  always_comb begin
    if (len == '0) dx_next = dl[MAG_W];
    else           dx_next = neg[MAG_W] ? -res : res;
  end

  always_ff @(posedge clk) begin
    if (en) dx <= dx_next;
  end
endmodule

/* sv/hcpf_isqrt.sv */
// Pipelined integer square root rounded to nearest, one result bit per stage.
module hcpf_isqrt import hcpf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [S_W-1:0]    s,
  output logic [DIST_W-1:0] root
);
  localparam int STEPS = S_W / 2;

  logic [S_W-1:0] sr  [STEPS+1];
  logic [S_W-1:0] res [STEPS+1];
  logic           up;

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0]  <= s;
      res[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [S_W-1:0] BIT = {{(S_W-1){1'b0}}, 1'b1} << (S_W - 2 - 2 * i);
    logic [S_W-1:0] t;
    logic           ge;
    assign t  = res[i] + BIT;
    assign ge = sr[i] >= t;
    always_ff @(posedge clk) begin
      if (en) begin
        sr[i+1]  <= ge ? sr[i] - t : sr[i];
        res[i+1] <= ge ? (res[i] >> 1) + BIT : res[i] >> 1;
      end
    end
  end

  assign up = sr[STEPS] > res[STEPS];

  always_ff @(posedge clk) begin
    if (en) root <= {1'b0, res[STEPS][DIST_W-2:0]} + {{(DIST_W-1){1'b0}}, up};
  end
endmodule

/* sv/hcpf_fdiv.sv */
// Pipelined force quotient: restoring divide of the product by the distance, then rounding.
module hcpf_fdiv import hcpf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [S_W-1:0]    p,
  input  logic [DIST_W-1:0] divisor,
  input  logic              k_hard,
  output logic [S_W-1:0]    tot
);
  localparam logic [NUM_W-1:0] K2_HARD = NUM_W'(2 * STIFF_HARD);
  localparam logic [NUM_W-1:0] K2_SOFT = NUM_W'(2 * STIFF_SOFT);
  localparam logic [S_W-1:0]   K_HARD  = S_W'(STIFF_HARD);

  logic [DIST_W-1:0] rem [S_W+1];
  logic [S_W-1:0]    nq  [S_W+1];
  logic [DIST_W-1:0] dv  [S_W+1];
  logic              kh  [S_W+1];

  logic [NUM_W-1:0]      nm  [FRAC_STEPS+1];
  logic [NUM_W-1:0]      den [FRAC_STEPS+1];
  logic [S_W-1:0]        kq  [FRAC_STEPS+1];
  logic [FRAC_STEPS-1:0] fq  [FRAC_STEPS+1];

  logic [NUM_W-1:0] r1w;
  logic [NUM_W-1:0] dvw;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      nq[0]  <= p;
      dv[0]  <= divisor;
      kh[0]  <= k_hard;
    end
  end

  for (genvar i = 0; i < S_W; i++) begin : g_div
    logic [DIST_W:0] t;
    logic [DIST_W:0] diff;
    logic            ge;
    assign t    = {rem[i], nq[i][S_W-1]};
    assign diff = t - {1'b0, dv[i]};
    assign ge   = t >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[DIST_W-1:0] : t[DIST_W-1:0];
        nq[i+1]  <= {nq[i][S_W-2:0], ge};
        dv[i+1]  <= dv[i];
        kh[i+1]  <= kh[i];
      end
    end
  end

  assign r1w = {{(NUM_W-DIST_W){1'b0}}, rem[S_W]};
  assign dvw = {{(NUM_W-DIST_W){1'b0}}, dv[S_W]};

  always_ff @(posedge clk) begin
    if (en) begin
      nm[0]  <= (kh[S_W] ? r1w * K2_HARD : r1w * K2_SOFT) + dvw;
      den[0] <= {dvw[NUM_W-2:0], 1'b0};
      kq[0]  <= kh[S_W] ? nq[S_W] * K_HARD : nq[S_W];
      fq[0]  <= '0;
    end
  end

  for (genvar j = 0; j < FRAC_STEPS; j++) begin : g_frac
    logic [NUM_W-1:0] dsh;
    logic             ge;
    assign dsh = den[j] << (FRAC_STEPS - 1 - j);
    assign ge  = nm[j] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        nm[j+1]  <= ge ? nm[j] - dsh : nm[j];
        den[j+1] <= den[j];
        kq[j+1]  <= kq[j];
        fq[j+1]  <= {fq[j][FRAC_STEPS-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) tot <= kq[FRAC_STEPS] + {{(S_W-FRAC_STEPS){1'b0}}, fq[FRAC_STEPS]};
  end
endmodule

/* sv/hysteretic_contact_pair_force_core.sv */
// Top level of the pair contact force core with hysteretic adhesion.
//
// A request on the s_t* channel carries one particle pair: indexes, positions,
// contact distance and bond flag. Each request gives exactly one result on
// the m_t* channel: the force on the first particle, the updated bond flag,
// the bonded count bit and four virial terms.
// The block accepts one request per cycle while the output is not stalled and returns results in order.
// The pipeline is built from the 32-step minimum-image divider, the
// 32-step square root and the 64-step force divider with its 7-step
// rounding divider.
// The whole pipeline advances together. When the receiver holds m_tready low
// with a result waiting, s_tready drops and every stage holds its contents;
// nothing is lost or repeated. Empty stages move on while the output is free.
// The box registers are written through cfg_we, cfg_index and cfg_data and
// should change only while no request is in flight. A box length of zero
// disables wrapping on that axis.
// Reset empties the pipeline and sets both box lengths to 64.0.
module hysteretic_contact_pair_force_core import hcpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // idx_a, idx_b, x_a, y_a, x_b, y_b, contact_distance, bonded
  input  logic [175:0]     s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // particle_a, particle_b, force_x, force_y, bonded_after, counts_bonded,
  // virial_xx, virial_yy, virial_xy, virial_yx, zero fill
  output logic [359:0]     m_tdata,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data
);
  localparam logic [71:0] V_LIM_POS = {9'd0, {63{1'b1}}};
  localparam logic [71:0] V_LIM_NEG = {8'd0, 1'b1, 63'd0};

  function automatic logic [MAG_W-1:0] dmag(input logic signed [DELTA_W-1:0] d);
    logic signed [DELTA_W-1:0] a;
    a = d[DELTA_W-1] ? -d : d;
    return a[MAG_W-1:0];
  endfunction

  function automatic logic [FORCE_W-1:0] sat_force(input logic [S_W-1:0] t,
                                                   input logic neg, input logic fz);
    logic [S_W-1:0]     lim;
    logic [S_W-1:0]     c;
    logic [FORCE_W-1:0] r;
    lim = {{(S_W-FORCE_W){1'b0}}, F_MAX} + {{(S_W-1){1'b0}}, neg};
    c   = (t > lim) ? lim : t;
    r   = neg ? -c[FORCE_W-1:0] : c[FORCE_W-1:0];
    return fz ? '0 : r;
  endfunction

  logic [LEN_W-1:0] box_width;
  logic [LEN_W-1:0] box_height;
  logic             en;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= LEN_W'(4194304);
      box_height <= LEN_W'(4194304);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BOX_WIDTH:  box_width  <= cfg_data;
        REG_BOX_HEIGHT: box_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = m_tready || !m_tvalid;
  assign s_tready = en && !rst;

  // Input stage.
  logic                      v0;
  logic signed [DELTA_W-1:0] delta_x0, delta_y0;
  pair_sb_t                  sb0;

  always_ff @(posedge clk) begin
    if (rst)     v0 <= 1'b0;
    else if (en) v0 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      delta_x0   <= {s_tdata[47], s_tdata[47:16]} - {s_tdata[111], s_tdata[111:80]};
      delta_y0   <= {s_tdata[79], s_tdata[79:48]} - {s_tdata[143], s_tdata[143:112]};
      sb0.idx_a  <= s_tdata[7:0];
      sb0.idx_b  <= s_tdata[15:8];
      sb0.sigma  <= s_tdata[174:144];
      sb0.bonded <= s_tdata[175];
    end
  end

  // Minimum image.
  logic                      v1p;
  pair_sb_t                  sb1;
  logic signed [DELTA_W-1:0] dx1, dy1;

  hcpf_minimg u_mi_x (.clk(clk), .en(en), .delta(delta_x0), .len(box_width),  .dx(dx1));
  hcpf_minimg u_mi_y (.clk(clk), .en(en), .delta(delta_y0), .len(box_height), .dx(dy1));
  hcpf_delay #(.W($bits(pair_sb_t)), .N(MI_LAT)) u_dl_mi (
    .clk(clk), .rst(rst), .en(en), .vin(v0), .din(sb0), .vout(v1p), .dout(sb1)
  );

  // Squares.
  logic                      v_t1;
  logic [S_W-1:0]            sqx, sqy;
  logic [2*LEN_W-1:0]        sig2;
  pair_sb_t                  sb_t1;
  logic signed [DELTA_W-1:0] dx_t1, dy_t1;

  always_ff @(posedge clk) begin
    if (rst)     v_t1 <= 1'b0;
    else if (en) v_t1 <= v1p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx   <= dmag(dx1) * dmag(dx1);
      sqy   <= dmag(dy1) * dmag(dy1);
      sig2  <= sb1.sigma * sb1.sigma;
      sb_t1 <= sb1;
      dx_t1 <= dx1;
      dy_t1 <= dy1;
    end
  end

  // Squared distance and contact decision.
  logic           v2;
  logic [S_W-1:0] s_sum, s2;
  logic           lt, le;
  geo_sb_t        g2;

  assign s_sum = sqx + sqy;
  assign lt    = s_sum < {2'b0, sig2};
  assign le    = s_sum <= {2'b0, sig2};

  always_ff @(posedge clk) begin
    if (rst)     v2 <= 1'b0;
    else if (en) v2 <= v_t1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2        <= s_sum;
      g2.sb     <= sb_t1;
      g2.dx     <= dx_t1;
      g2.dy     <= dy_t1;
      g2.after  <= sb_t1.bonded || le;
      g2.k_hard <= sb_t1.bonded ? lt : 1'b1;
      g2.fz     <= !(sb_t1.bonded || le) || (s_sum == '0);
    end
  end

  // Distance.
  logic              v3p;
  logic [DIST_W-1:0] dist3;
  geo_sb_t           g3;

  hcpf_isqrt u_isqrt (.clk(clk), .en(en), .s(s2), .root(dist3));
  hcpf_delay #(.W($bits(geo_sb_t)), .N(ISQ_LAT)) u_dl_isq (
    .clk(clk), .rst(rst), .en(en), .vin(v2), .din(g2), .vout(v3p), .dout(g3)
  );

  // Overlap sigma - dist.
  logic              v3a;
  logic [DIST_W:0]   m_diff;
  logic [DIST_W-1:0] mmag_a;
  logic              mneg_a;
  logic [DIST_W-1:0] dist_a;
  logic [MAG_W-1:0]  dmx_a, dmy_a;
  geo_sb_t           g3a;

  assign m_diff = {3'b0, g3.sb.sigma} - {1'b0, dist3};

  always_ff @(posedge clk) begin
    if (rst)     v3a <= 1'b0;
    else if (en) v3a <= v3p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mneg_a <= m_diff[DIST_W];
      mmag_a <= m_diff[DIST_W] ? -m_diff[DIST_W-1:0] : m_diff[DIST_W-1:0];
      dist_a <= dist3;
      dmx_a  <= dmag(g3.dx);
      dmy_a  <= dmag(g3.dy);
      g3a    <= g3;
    end
  end

  // Product |d| * |m|, low part.
  logic              v3b;
  logic [S_W-1:0]    plo_x, plo_y, p_x, p_y;
  logic              m32;
  logic [DIST_W-1:0] dist_b;
  logic [MAG_W-1:0]  dmx_b, dmy_b;
  logic              k_hard_b;
  frc_sb_t           f3b;

  always_ff @(posedge clk) begin
    if (rst)     v3b <= 1'b0;
    else if (en) v3b <= v3a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_x      <= dmx_a * mmag_a[MAG_W-1:0];
      plo_y      <= dmy_a * mmag_a[MAG_W-1:0];
      m32        <= mmag_a[DIST_W-1];
      dist_b     <= dist_a;
      dmx_b      <= dmx_a;
      dmy_b      <= dmy_a;
      k_hard_b   <= g3a.k_hard;
      f3b.idx_a  <= g3a.sb.idx_a;
      f3b.idx_b  <= g3a.sb.idx_b;
      f3b.bonded <= g3a.sb.bonded;
      f3b.after  <= g3a.after;
      f3b.fz     <= g3a.fz;
      f3b.neg_x  <= g3a.dx[DELTA_W-1] != mneg_a;
      f3b.neg_y  <= g3a.dy[DELTA_W-1] != mneg_a;
      f3b.dx     <= g3a.dx;
      f3b.dy     <= g3a.dy;
    end
  end

  assign p_x = plo_x + (m32 ? {dmx_b, {MAG_W{1'b0}}} : '0);
  assign p_y = plo_y + (m32 ? {dmy_b, {MAG_W{1'b0}}} : '0);

  // Force quotient.
  logic           v4p;
  logic [S_W-1:0] tot_x, tot_y;
  frc_sb_t        f4;

  hcpf_fdiv u_fdiv_x (.clk(clk), .en(en), .p(p_x), .divisor(dist_b), .k_hard(k_hard_b),
                      .tot(tot_x));
  hcpf_fdiv u_fdiv_y (.clk(clk), .en(en), .p(p_y), .divisor(dist_b), .k_hard(k_hard_b),
                      .tot(tot_y));
  hcpf_delay #(.W($bits(frc_sb_t)), .N(FD_LAT)) u_dl_fd (
    .clk(clk), .rst(rst), .en(en), .vin(v3b), .din(f3b), .vout(v4p), .dout(f4)
  );

  // Saturated force.
  logic               v4;
  logic [FORCE_W-1:0] fx4, fy4;
  frc_sb_t            f4r;

  always_ff @(posedge clk) begin
    if (rst)     v4 <= 1'b0;
    else if (en) v4 <= v4p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx4 <= sat_force(tot_x, f4.neg_x, f4.fz);
      fy4 <= sat_force(tot_y, f4.neg_y, f4.fz);
      f4r <= f4;
    end
  end

  // Virials: split products, sum, saturate.
  logic [FORCE_W-1:0]        vf [4];
  logic [FORCE_W-1:0]        vfa [4];
  logic signed [DELTA_W-1:0] vd [4];
  logic                      vv1, vv2;
  logic [S_W-1:0]            vlo [4];
  logic [FORCE_W-1:0]        vhi [4];
  logic                      vneg1 [4];
  logic [71:0]               vprod [4];
  logic                      vneg2 [4];
  logic [FORCE_W-1:0]        fx5, fy5, fx6, fy6;
  frc_sb_t                   f5, f6;
  logic [VIR_W-1:0]          vout [4];

  assign vf[0] = fx4;
  assign vd[0] = f4r.dx;
  assign vf[1] = fy4;
  assign vd[1] = f4r.dy;
  assign vf[2] = fx4;
  assign vd[2] = f4r.dy;
  assign vf[3] = fy4;
  assign vd[3] = f4r.dx;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vfa[i] = vf[i][FORCE_W-1] ? -vf[i] : vf[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv1      <= 1'b0;
      vv2      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vv1      <= v4;
      vv2      <= vv1;
      m_tvalid <= vv2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        vlo[i]   <= vfa[i][MAG_W-1:0] * dmag(vd[i]);
        vhi[i]   <= vfa[i] >> MAG_W;
        vneg1[i] <= vf[i][FORCE_W-1] != vd[i][DELTA_W-1];
      end
      fx5 <= fx4;
      fy5 <= fy4;
      f5  <= f4r;
    end
  end

  logic [MAG_W-1:0] vd5 [4];
  assign vd5[0] = dmag(f5.dx);
  assign vd5[1] = dmag(f5.dy);
  assign vd5[2] = dmag(f5.dy);
  assign vd5[3] = dmag(f5.dx);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        vprod[i] <= {8'd0, vlo[i]}
                  + {vhi[i][FORCE_W-MAG_W-1:0] * {8'd0, vd5[i]}, {MAG_W{1'b0}}};
        vneg2[i] <= vneg1[i];
      end
      fx6 <= fx5;
      fy6 <= fy5;
      f6  <= f5;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (vneg2[i]) vout[i] = -((vprod[i] > V_LIM_NEG) ? V_LIM_NEG[VIR_W-1:0]
                                                     : vprod[i][VIR_W-1:0]);
      else          vout[i] = (vprod[i] > V_LIM_POS) ? V_LIM_POS[VIR_W-1:0]
                                                     : vprod[i][VIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'd0, vout[3], vout[2], vout[1], vout[0], f6.bonded, f6.after,
                  fy6, fx6, f6.idx_b, f6.idx_a};
    end
  end

  a_bond_kept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[97] |-> m_tdata[96])
    else $error("bonded pair lost its bond");

  a_free_no_force: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[96] |-> m_tdata[95:16] == '0)
    else $error("unbonded pair without contact has a force");

  a_virial_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[55:16] == '0 |-> m_tdata[161:98] == '0 && m_tdata[289:226] == '0)
    else $error("zero force_x with nonzero virial");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");
endmodule

/* dv/tb.sv */
// Self-checking testbench for the pair contact force core: directed table plus random pairs.
`timescale 1ns / 1ps
module tb import hcpf_pkg::*; ();

  typedef struct {
    logic [7:0]  ia, ib;
    logic [31:0] xa, ya, xb, yb;
    logic [30:0] sig;
    logic        bnd;
  } pair_t;

  typedef struct {
    logic [7:0]  pa, pb;
    logic [39:0] fx, fy;
    logic        aft, cnt;
    logic [63:0] vxx, vyy, vxy, vyx;
  } force_t;

  typedef struct {
    pair_t  p;
    logic   chk;
    force_t f;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [175:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [359:0] m_tdata;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [LEN_W-1:0] cfg_data = '0;

  hysteretic_contact_pair_force_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  longint box_w, box_h;
  force_t expected_forces[$];
  int mismatches = 0;
  bit sink_hold = 0;
  bit random_stall = 1;

  function automatic longint wrap_axis(longint delta, longint len);
    longint q, r;
    if (len == 0) return delta;
    q = delta / len;
    r = delta - q * len;
    if (r < 0) begin
      r += len;
      q -= 1;
    end
    if (2 * r > len || (2 * r == len && q[0])) q += 1;
    return delta - q * len;
  endfunction

  function automatic longint unsigned round_sqrt(longint unsigned s);
    longint unsigned lo = 0, hi = 64'hffffffff, mid;
    // floor root by bisection, then round
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= s) lo = mid;
      else hi = mid - 1;
    end
    if (s - lo * lo > lo) lo += 1;
    return lo;
  endfunction

  function automatic logic [39:0] axis_pull(longint d, longint m, longint unsigned dlen,
                                            longint unsigned k);
    bit neg;
    longint unsigned p, q1, r1, tot;
    neg = (d < 0) != (m < 0);
    p = longint'(d < 0 ? -d : d) * longint'(m < 0 ? -m : m);
    q1 = p / dlen;
    r1 = p % dlen;
    tot = k * q1 + (2 * k * r1 + dlen) / (2 * dlen);
    if (neg) begin
      if (tot > 64'd549755813888) tot = 64'd549755813888;
      return 40'(-tot);
    end
    if (tot > 64'd549755813887) tot = 64'd549755813887;
    return 40'(tot);
  endfunction

  function automatic logic [63:0] virial_term(logic [39:0] f, longint d);
    longint fs;
    bit neg;
    longint unsigned af, ad, lim;
    fs = longint'($signed(f));
    neg = (fs < 0) != (d < 0);
    af = fs < 0 ? -fs : fs;
    ad = d < 0 ? -d : d;
    if (af == 0 || ad == 0) return 0;
    lim = neg ? 64'h8000000000000000 : 64'h7fffffffffffffff;
    if (af > lim / ad) return neg ? lim : lim;
    return neg ? -(af * ad) : af * ad;
  endfunction

  function automatic force_t pair_force(pair_t p);
    force_t f;
    longint dx, dy, m;
    longint unsigned s, sig2, k, dlen;
    dx = wrap_axis(longint'($signed(p.xa)) - longint'($signed(p.xb)), box_w);
    dy = wrap_axis(longint'($signed(p.ya)) - longint'($signed(p.yb)), box_h);
    s = longint'(dx < 0 ? -dx : dx) * longint'(dx < 0 ? -dx : dx)
      + longint'(dy < 0 ? -dy : dy) * longint'(dy < 0 ? -dy : dy);
    sig2 = longint'(p.sig) * longint'(p.sig);
    k = 0;
    f.aft = 0;
    if (p.bnd) begin
      f.aft = 1;
      k = s < sig2 ? STIFF_HARD : STIFF_SOFT;
    end else if (s <= sig2) begin
      f.aft = 1;
      k = STIFF_HARD;
    end
    f.fx = 0;
    f.fy = 0;
    if (k != 0 && s != 0) begin
      dlen = round_sqrt(s);
      m = longint'(p.sig) - longint'(dlen);
      f.fx = axis_pull(dx, m, dlen, k);
      f.fy = axis_pull(dy, m, dlen, k);
    end
    f.pa = p.ia;
    f.pb = p.ib;
    f.cnt = p.bnd;
    f.vxx = virial_term(f.fx, dx);
    f.vyy = virial_term(f.fy, dy);
    f.vxy = virial_term(f.fx, dy);
    f.vyx = virial_term(f.fy, dx);
    return f;
  endfunction

  task automatic write_box(reg_idx_t idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_BOX_WIDTH) box_w = val;
    else box_h = val;
  endtask

  task automatic send_pair(pair_t p, bit has_f, force_t f);
    expected_forces.push_back(has_f ? f : pair_force(p));
    s_tdata <= {p.bnd, p.sig, p.yb, p.xb, p.ya, p.xa, p.ib, p.ia};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  function automatic pair_t rand_pair(int mode);
    pair_t p;
    int r;
    p.ia = 8'($urandom);
    p.ib = 8'($urandom);
    p.bnd = 1'($urandom);
    if (mode == 0) begin
      p.xa = $urandom;
      p.ya = $urandom;
      p.xb = $urandom;
      p.yb = $urandom;
      p.sig = 31'($urandom);
    end else begin
      // close pairs that land near the contact distance
      p.xa = $urandom;
      p.ya = $urandom;
      r = $urandom_range(0, 4 << 16);
      p.xb = p.xa + $signed($urandom_range(0, 2 * r)) - r;
      p.yb = p.ya + $signed($urandom_range(0, 2 * r)) - r;
      p.sig = 31'($urandom_range(0, 6 << 16));
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          force_t e;
          logic [353:0] w;
          e = expected_forces.pop_front();
          w = {e.vyx, e.vxy, e.vyy, e.vxx, e.cnt, e.aft, e.fy, e.fx, e.pb, e.pa};
          if (m_tdata[353:0] !== w || m_tdata[359:354] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", {6'd0, w}, m_tdata);
          end
        end
      end
      m_tready <= !sink_hold && (!random_stall || ($urandom_range(0, 3) != 0));
    end
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t r;
    force_t z;
    int burst;
    int ph;
    box_w = 4194304;
    box_h = 4194304;
    repeat (10) @(posedge clk);
    rst <= 0;
    z = '{default: 0};
    // coincident unbonded pair: zero force, becomes bonded
    r.p = '{8'h00, 8'hff, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0};
    r.chk = 1; r.f = z; r.f.pb = 8'hff; r.f.aft = 1; rows.push_back(r);
    // far unbonded pair: no contact
    r.p = '{8'hff, 8'h00, 32'h0, 32'h0, 32'h00100000, 32'h0, 31'h10000, 1'b0};
    r.chk = 1; r.f = z; r.f.pa = 8'hff; rows.push_back(r);
    // bonded coincident
    r.p = '{8'h1, 8'h2, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
            31'h7fffffff, 1'b1};
    r.chk = 1; r.f = z; r.f.pa = 1; r.f.pb = 2; r.f.aft = 1; r.f.cnt = 1;
    rows.push_back(r);
    r.chk = 0;
    r.p = '{8'h3, 8'h4, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
            31'h7fffffff, 1'b1}; rows.push_back(r);
    r.p = '{8'h5, 8'h6, 32'h0, 32'h0, 32'h00010000, 32'h0, 31'h00010000, 1'b0};
    rows.push_back(r);
    r.p = '{8'h7, 8'h8, 32'h0, 32'h0, 32'h00010000, 32'h0, 31'h00010000, 1'b1};
    rows.push_back(r);
    r.p = '{8'h9, 8'ha, 32'h0, 32'h0, 32'h00008000, 32'h00008000, 31'h00030000, 1'b0};
    rows.push_back(r);
    r.p = '{8'hb, 8'hc, 32'h0, 32'h0, 32'h00200000, 32'h0, 31'h0, 1'b1};
    rows.push_back(r);
    r.p = '{8'hd, 8'he, 32'h0, 32'h0, 32'h00200000, 32'h00200000, 31'h0, 1'b1};
    rows.push_back(r);
    r.p = '{8'hf, 8'h10, 32'h1, 32'h0, 32'h0, 32'h0, 31'h7fffffff, 1'b0};
    rows.push_back(r);
    r.p = '{8'h11, 8'h12, 32'h0, 32'h1, 32'h0, 32'h0, 31'h7fffffff, 1'b1};
    rows.push_back(r);
    r.p = '{8'h13, 8'h14, 32'hffffffff, 32'h5555aaaa, 32'haaaa5555, 32'h0,
            31'h2aaaaaaa, 1'b1}; rows.push_back(r);
    foreach (rows[i]) send_pair(rows[i].p, rows[i].chk, rows[i].f);
    drain();
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_box(REG_BOX_WIDTH, 31'h0);
          write_box(REG_BOX_HEIGHT, 31'h7fffffff);
        end
        1: begin
          write_box(REG_BOX_WIDTH, 31'h10000);
          write_box(REG_BOX_HEIGHT, 31'h10000);
        end
        2: begin
          write_box(REG_BOX_WIDTH, 31'h7fffffff);
          write_box(REG_BOX_HEIGHT, 31'h0);
        end
        3: begin
          write_box(REG_BOX_WIDTH, 31'h00030000);
          write_box(REG_BOX_HEIGHT, 31'h00050001);
        end
        default: begin
          write_box(REG_BOX_WIDTH, 31'($urandom_range(65536, 32'h7fffffff)));
          write_box(REG_BOX_HEIGHT, 31'($urandom_range(65536, 32'h00800000)));
        end
      endcase
      if (ph == 1) begin
        fork
          begin
            @(posedge clk);
            sink_hold = 1;
            repeat (400) @(posedge clk);
            sink_hold = 0;
          end
        join_none
      end
      random_stall = (ph != 4);
      for (int n = 0; n < 200;) begin
        burst = $urandom_range(1, 30);
        for (int b = 0; b < burst && n < 200; b++, n++) begin
          force_t nf;
          send_pair(rand_pair($urandom_range(0, 3) != 0), 0, nf);
        end
        if (ph != 4 && $urandom_range(0, 1)) begin
          s_tvalid <= 0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
      drain();
    end
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* sim.f */
sv/hcpf_pkg.sv
sv/hcpf_delay.sv
sv/hcpf_minimg.sv
sv/hcpf_isqrt.sv
sv/hcpf_fdiv.sv
sv/hysteretic_contact_pair_force_core.sv
dv/tb.sv
